/* hw/rtl/pmsa_pkg.sv */
// Shared types, widths and codes of the pixel mean and deviation accumulator.
package pmsa_pkg;

  localparam int MAX_DIMS  = 4096;
  localparam int ADDR_W    = 12;
  localparam int SUM_W     = 24;
  localparam int SQ_W      = 32;
  localparam int RAM_W     = SUM_W + SQ_W;
  localparam int CH_SUM_W  = 35;
  localparam int CH_SQ_W   = 43;
  localparam int CNT_W     = 16;
  localparam int DIMS_W    = 13;
  localparam int LOCS_W    = 11;
  localparam int N_W       = 28;
  localparam int S_W       = 36;
  localparam int Q_W       = 44;
  localparam int PROD_W    = 72;
  localparam int RAD_W     = 104;
  localparam int ROOT_W    = 52;
  localparam int DIV_W     = 52;
  localparam int VAL_W     = 24;
  localparam int NUM_PLANES = 3;

  localparam logic [DIMS_W-1:0] DIMS_RESET  = 13'd3072;
  localparam logic [LOCS_W-1:0] LOCS_RESET  = 11'd1024;
  localparam logic [CNT_W-1:0]  LIMIT_RESET = 16'd10000;

  typedef enum logic [1:0] {
    OP_ACCUM  = 2'd0,
    OP_RD_DIM = 2'd1,
    OP_RD_CH  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_DIMS  = 2'd0,
    CFG_LOCS  = 2'd1,
    CFG_LIMIT = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic             start;
    logic [N_W-1:0]   n;
    logic [S_W-1:0]   s;
    logic [Q_W-1:0]   q;
  } stats_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] mean;
    logic [VAL_W-1:0] dev;
  } stats_res_t;

endpackage

/* hw/rtl/pmsa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pmsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/pmsa_stats.sv */
// Bit-serial mean and population deviation unit: divide, multiply and square root steps.
module pmsa_stats (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pmsa_pkg::stats_req_t  req,
  output pmsa_pkg::stats_res_t  res
);

  localparam logic [5:0] DIV_LAST  = 6'(pmsa_pkg::DIV_W - 1);
  localparam logic [5:0] MULQ_LAST = 6'(pmsa_pkg::N_W - 1);
  localparam logic [5:0] MULS_LAST = 6'(pmsa_pkg::S_W - 1);
  localparam logic [5:0] SQRT_LAST = 6'(pmsa_pkg::ROOT_W - 1);

  typedef enum logic [6:0] {
    SS_IDLE = 7'b0000001,
    SS_DIVM = 7'b0000010,
    SS_MULQ = 7'b0000100,
    SS_MULS = 7'b0001000,
    SS_CMP  = 7'b0010000,
    SS_SQRT = 7'b0100000,
    SS_DIVD = 7'b1000000
  } ss_state_t;

  ss_state_t                    state_r;
  logic [5:0]                   cnt_r;
  logic [pmsa_pkg::N_W-1:0]     n_r;
  logic [pmsa_pkg::PROD_W-1:0]  acc_r;
  logic [pmsa_pkg::PROD_W-1:0]  mcand_r;
  logic [pmsa_pkg::S_W-1:0]     mplier_r;
  logic [pmsa_pkg::PROD_W-1:0]  prod_r;
  logic [pmsa_pkg::RAD_W-1:0]   rad_r;
  logic [pmsa_pkg::ROOT_W-1:0]  root_r;
  logic [53:0]                  rem_r;
  logic [pmsa_pkg::DIV_W-1:0]   dvd_r;
  logic [pmsa_pkg::N_W-1:0]     drem_r;
  logic [pmsa_pkg::VAL_W-1:0]   mean_r;
  logic [pmsa_pkg::VAL_W-1:0]   dev_r;
  logic                         done_r;

  logic [pmsa_pkg::N_W:0]       div_cur;
  logic [pmsa_pkg::N_W:0]       div_diff;
  logic                         div_ge;
  logic [pmsa_pkg::N_W-1:0]     drem_nxt;
  logic [pmsa_pkg::DIV_W-1:0]   dvd_nxt;
  logic [pmsa_pkg::VAL_W-1:0]   div_sat;
  logic [pmsa_pkg::PROD_W-1:0]  acc_nxt;
  logic [55:0]                  sq_cur;
  logic [55:0]                  sq_trial;
  logic [55:0]                  sq_diff;
  logic                         sq_ge;
  logic [53:0]                  rem_nxt;
  logic [pmsa_pkg::ROOT_W-1:0]  root_nxt;

  always_comb begin
    div_cur  = {drem_r, dvd_r[pmsa_pkg::DIV_W-1]};
    div_diff = div_cur - {1'b0, n_r};
    div_ge   = div_cur >= {1'b0, n_r};
    drem_nxt = div_ge ? div_diff[pmsa_pkg::N_W-1:0] : div_cur[pmsa_pkg::N_W-1:0];
    dvd_nxt  = {dvd_r[pmsa_pkg::DIV_W-2:0], div_ge};
    div_sat  = (|dvd_nxt[pmsa_pkg::DIV_W-1:pmsa_pkg::VAL_W]) ? '1
             : dvd_nxt[pmsa_pkg::VAL_W-1:0];
    acc_nxt  = acc_r + (mplier_r[0] ? mcand_r : '0);
    sq_cur   = {rem_r, rad_r[pmsa_pkg::RAD_W-1 -: 2]};
    sq_trial = {2'b00, root_r, 2'b01};
    sq_diff  = sq_cur - sq_trial;
    sq_ge    = sq_cur >= sq_trial;
    rem_nxt  = sq_ge ? sq_diff[53:0] : sq_cur[53:0];
    root_nxt = {root_r[pmsa_pkg::ROOT_W-2:0], sq_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        SS_IDLE: begin
          done_r <= 1'b0;
          if (req.start) begin
            n_r     <= req.n;
            mplier_r <= {{(pmsa_pkg::S_W-pmsa_pkg::N_W){1'b0}}, req.n};
            mcand_r <= {{(pmsa_pkg::PROD_W-pmsa_pkg::Q_W){1'b0}}, req.q};
            acc_r   <= '0;
            prod_r  <= {{(pmsa_pkg::PROD_W-pmsa_pkg::S_W){1'b0}}, req.s};
            dvd_r   <= {req.s, 16'h0000};
            drem_r  <= '0;
            cnt_r   <= '0;
            state_r <= SS_DIVM;
          end
        end
        SS_DIVM: begin
          done_r <= 1'b0;
          dvd_r  <= dvd_nxt;
          drem_r <= drem_nxt;
          if (cnt_r == DIV_LAST) begin
            mean_r  <= div_sat;
            cnt_r   <= '0;
            state_r <= SS_MULQ;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        SS_MULQ: begin
          done_r <= 1'b0;
          if (cnt_r == MULQ_LAST) begin
            acc_r    <= '0;
            mcand_r  <= prod_r;
            mplier_r <= prod_r[pmsa_pkg::S_W-1:0];
            prod_r   <= acc_nxt;
            cnt_r    <= '0;
            state_r  <= SS_MULS;
          end else begin
            acc_r    <= acc_nxt;
            mcand_r  <= {mcand_r[pmsa_pkg::PROD_W-2:0], 1'b0};
            mplier_r <= {1'b0, mplier_r[pmsa_pkg::S_W-1:1]};
            cnt_r    <= cnt_r + 6'd1;
          end
        end
        SS_MULS: begin
          done_r   <= 1'b0;
          acc_r    <= acc_nxt;
          mcand_r  <= {mcand_r[pmsa_pkg::PROD_W-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[pmsa_pkg::S_W-1:1]};
          if (cnt_r == MULS_LAST) begin
            cnt_r   <= '0;
            state_r <= SS_CMP;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        SS_CMP: begin
          if (prod_r < acc_r) begin
            dev_r   <= '0;
            done_r  <= 1'b1;
            state_r <= SS_IDLE;
          end else begin
            done_r  <= 1'b0;
            rad_r   <= {prod_r - acc_r, 32'h0};
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= SS_SQRT;
          end
        end
        SS_SQRT: begin
          done_r <= 1'b0;
          rad_r  <= {rad_r[pmsa_pkg::RAD_W-3:0], 2'b00};
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          if (cnt_r == SQRT_LAST) begin
            dvd_r   <= root_nxt;
            drem_r  <= '0;
            cnt_r   <= '0;
            state_r <= SS_DIVD;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        SS_DIVD: begin
          dvd_r  <= dvd_nxt;
          drem_r <= drem_nxt;
          if (cnt_r == DIV_LAST) begin
            dev_r   <= div_sat;
            done_r  <= 1'b1;
            cnt_r   <= '0;
            state_r <= SS_IDLE;
          end else begin
            done_r <= 1'b0;
            cnt_r  <= cnt_r + 6'd1;
          end
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= SS_IDLE;
        end
      endcase
    end
  end

  assign res.done = done_r;
  assign res.mean = mean_r;
  assign res.dev  = dev_r;

endmodule

/* hw/rtl/pixel_mean_std_accumulator.sv */
// Top level: per-dimension and per-channel mean and deviation accumulator.
//
//  channel  direction  tdata (low bit up)                       tuser
//  in_      slave      pixel[7:0] select_index[19:8] pad        operation[1:0]
//  out_     master     mean[23:0] deviation[47:24] images[63:48] no_data[0]
//  cfg_     write      cfg_index 0 dims, 1 locations, 2 limit; cfg_data
//
//  Accumulate: a RAM read-modify-write of the sums per item, with in_tready low until
//  it is written back. Dimension and channel reads wait for the bit-serial divide,
//  multiply and square root unit; an invalid read skips it and answers with no_data.
//  Reset and clear sweep the 4096-entry RAM with in_tready low.
//  A held result does not stop accumulates or clears; a read waits for the output.
module pixel_mean_std_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel[7:0], select_index[19:8], zero pad
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // mean_value[23:0], deviation_value[47:24], images_seen[63:48]
  output logic [0:0]  out_tuser,  // no_data[0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_ACC   = 6'b000100,
    ST_RDMEM = 6'b001000,
    ST_STATS = 6'b010000,
    ST_LOAD  = 6'b100000
  } state_t;

  state_t                                state_r;
  logic [pmsa_pkg::DIMS_W-1:0]           dim_cnt_r;
  logic [pmsa_pkg::LOCS_W-1:0]           locs_r;
  logic [pmsa_pkg::CNT_W-1:0]            limit_r;
  logic [pmsa_pkg::CNT_W-1:0]            img_cnt_r;
  logic [pmsa_pkg::ADDR_W-1:0]           byte_pos_r;
  logic [pmsa_pkg::LOCS_W-1:0]           plane_pos_r;
  logic [1:0]                            plane_num_r;
  logic [pmsa_pkg::CH_SUM_W-1:0]         ch_sum_r [pmsa_pkg::NUM_PLANES];
  logic [pmsa_pkg::CH_SQ_W-1:0]          ch_sq_r  [pmsa_pkg::NUM_PLANES];
  logic [pmsa_pkg::ADDR_W-1:0]           clr_addr_r;
  logic [7:0]                            px_r;
  logic                                  nodata_r;
  logic                                  out_valid_r;
  logic [63:0]                           out_data_r;
  logic                                  out_nodata_r;

  pmsa_pkg::op_t                         op;
  logic [7:0]                            px;
  logic [pmsa_pkg::ADDR_W-1:0]           sel;
  logic                                  in_acc;
  logic [pmsa_pkg::DIMS_W-1:0]           dims_eff;
  logic [pmsa_pkg::LOCS_W-1:0]           locs_eff;
  logic                                  dim_ok;
  logic                                  ch_ok;
  logic [1:0]                            ch_idx;
  logic [26:0]                           ch_n;
  logic [pmsa_pkg::ADDR_W-1:0]           ram_raddr;
  logic [pmsa_pkg::RAM_W-1:0]            ram_rdata;
  logic                                  ram_we;
  logic [pmsa_pkg::ADDR_W-1:0]           ram_waddr;
  logic [pmsa_pkg::RAM_W-1:0]            ram_wdata;
  logic [pmsa_pkg::SUM_W-1:0]            rd_sum;
  logic [pmsa_pkg::SQ_W-1:0]             rd_sq;
  logic [15:0]                           px_sq;
  logic [pmsa_pkg::LOCS_W:0]             pp1;
  logic [pmsa_pkg::DIMS_W-1:0]           bp1;
  logic                                  out_free;
  pmsa_pkg::stats_req_t                  st_req;
  pmsa_pkg::stats_res_t                  st_res;

  assign op        = pmsa_pkg::op_t'(in_tuser);
  assign px        = in_tdata[7:0];
  assign sel       = in_tdata[19:8];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign dims_eff = (dim_cnt_r == '0) ? 13'd1
                  : (dim_cnt_r > 13'(pmsa_pkg::MAX_DIMS)) ? 13'(pmsa_pkg::MAX_DIMS)
                  : dim_cnt_r;
  assign locs_eff = (locs_r == '0) ? 11'd1 : locs_r;
  assign dim_ok   = ({1'b0, sel} < dims_eff) && (img_cnt_r != '0);
  assign ch_ok    = (sel < 12'(pmsa_pkg::NUM_PLANES)) && (img_cnt_r != '0);
  assign ch_idx   = ch_ok ? sel[1:0] : 2'd0;
  assign ch_n     = img_cnt_r * locs_eff;

  assign rd_sum = ram_rdata[pmsa_pkg::SUM_W-1:0];
  assign rd_sq  = ram_rdata[pmsa_pkg::RAM_W-1:pmsa_pkg::SUM_W];
  assign px_sq  = px_r * px_r;
  assign pp1    = {1'b0, plane_pos_r} + 12'd1;
  assign bp1    = {1'b0, byte_pos_r} + 13'd1;

  assign ram_raddr = (op == pmsa_pkg::OP_RD_DIM) ? sel : byte_pos_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = byte_pos_r;
    ram_wdata = {rd_sq + {16'h0000, px_sq}, rd_sum + {16'h0000, px_r}};
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (state_r == ST_ACC) begin
      ram_we = 1'b1;
    end
  end

  pmsa_ram #(
    .WIDTH (pmsa_pkg::RAM_W),
    .DEPTH (pmsa_pkg::MAX_DIMS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    st_req.start = (state_r == ST_RDMEM)
                || (in_acc && (op == pmsa_pkg::OP_RD_CH) && ch_ok);
    if (state_r == ST_RDMEM) begin
      st_req.n = {12'h000, img_cnt_r};
      st_req.s = {12'h000, rd_sum};
      st_req.q = {12'h000, rd_sq};
    end else begin
      st_req.n = {1'b0, ch_n};
      st_req.s = {1'b0, ch_sum_r[ch_idx]};
      st_req.q = {1'b0, ch_sq_r[ch_idx]};
    end
  end

  pmsa_stats u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .res   (st_res)
  );

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      dim_cnt_r   <= pmsa_pkg::DIMS_RESET;
      locs_r      <= pmsa_pkg::LOCS_RESET;
      limit_r     <= pmsa_pkg::LIMIT_RESET;
      img_cnt_r   <= '0;
      byte_pos_r  <= '0;
      plane_pos_r <= '0;
      plane_num_r <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < pmsa_pkg::NUM_PLANES; i++) begin
        ch_sum_r[i] <= '0;
        ch_sq_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (pmsa_pkg::cfg_idx_t'(cfg_index))
          pmsa_pkg::CFG_DIMS:  dim_cnt_r <= cfg_data[pmsa_pkg::DIMS_W-1:0];
          pmsa_pkg::CFG_LOCS:  locs_r    <= cfg_data[pmsa_pkg::LOCS_W-1:0];
          pmsa_pkg::CFG_LIMIT: limit_r   <= cfg_data;
          default: ;
        endcase
      end
      if ((state_r == ST_LOAD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 12'd1;
          if (clr_addr_r == 12'(pmsa_pkg::MAX_DIMS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            px_r <= px;
            case (op)
              pmsa_pkg::OP_ACCUM: begin
                if (img_cnt_r < limit_r) begin
                  state_r <= ST_ACC;
                end
              end
              pmsa_pkg::OP_RD_DIM: begin
                nodata_r <= !dim_ok;
                state_r  <= dim_ok ? ST_RDMEM : ST_LOAD;
              end
              pmsa_pkg::OP_RD_CH: begin
                nodata_r <= !ch_ok;
                state_r  <= ch_ok ? ST_STATS : ST_LOAD;
              end
              pmsa_pkg::OP_CLEAR: begin
                img_cnt_r   <= '0;
                byte_pos_r  <= '0;
                plane_pos_r <= '0;
                plane_num_r <= '0;
                clr_addr_r  <= '0;
                for (int i = 0; i < pmsa_pkg::NUM_PLANES; i++) begin
                  ch_sum_r[i] <= '0;
                  ch_sq_r[i]  <= '0;
                end
                state_r <= ST_CLEAR;
              end
              default: ;
            endcase
          end
        end
        ST_ACC: begin
          if (plane_num_r < 2'(pmsa_pkg::NUM_PLANES)) begin
            ch_sum_r[plane_num_r] <= ch_sum_r[plane_num_r] + {27'h0, px_r};
            ch_sq_r[plane_num_r]  <= ch_sq_r[plane_num_r] + {27'h0, px_sq};
          end
          if (bp1 >= dims_eff) begin
            byte_pos_r  <= '0;
            plane_pos_r <= '0;
            plane_num_r <= '0;
            img_cnt_r   <= img_cnt_r + 16'd1;
          end else begin
            byte_pos_r <= bp1[pmsa_pkg::ADDR_W-1:0];
            if (pp1 >= {1'b0, locs_eff}) begin
              plane_pos_r <= '0;
              if (plane_num_r < 2'(pmsa_pkg::NUM_PLANES)) begin
                plane_num_r <= plane_num_r + 2'd1;
              end
            end else begin
              plane_pos_r <= pp1[pmsa_pkg::LOCS_W-1:0];
            end
          end
          state_r <= ST_IDLE;
        end
        ST_RDMEM: begin
          state_r <= ST_STATS;
        end
        ST_STATS: begin
          if (st_res.done) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            out_nodata_r <= nodata_r;
            out_data_r   <= nodata_r ? {img_cnt_r, 48'h0}
                          : {img_cnt_r, st_res.dev, st_res.mean};
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_nodata_r;

  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_nodata_r) |-> (out_data_r[47:0] == 48'h0))
    else $error("no_data result carries nonzero values");

  a_acc_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (op == pmsa_pkg::OP_ACCUM) && (img_cnt_r < limit_r)) |=> (state_r == ST_ACC))
    else $error("accumulate below limit not applied");

  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CLEAR) && (clr_addr_r == 12'(pmsa_pkg::MAX_DIMS - 1)))
    |=> (state_r == ST_IDLE))
    else $error("clear sweep did not finish");

  a_done_in_stats: assert property (@(posedge clk) disable iff (!rst_n)
    st_res.done |-> (state_r == ST_STATS))
    else $error("statistics finished outside a read");

endmodule
